// ===== design/b64d_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// b64d_pkg
// Types, codes and the character map shared by the Base64 stream decoder.
// ============================================================================
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;

    typedef enum logic [1:0] {
        STATUS_DATA    = 2'd0,
        STATUS_LENGTH  = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        s.ok    = 1'b1;
        s.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            s.value = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            s.value = 6'(c - 8'h47);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            s.value = 6'(c + 8'h04);
        end
        else if (c == PLUS_CHAR)
        begin
            s.value = 6'd62;
        end
        else if (c == SLASH_CHAR)
        begin
            s.value = 6'd63;
        end
        else if (c == PAD_CHAR)
        begin
            s.value = 6'd0;
        end
        else
        begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

// ===== design/base64_stream_decoder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// base64_stream_decoder
// Streaming Base64 decoder, one character in per word, one byte out per word.
// ============================================================================
// A character is taken into an input register and decoded from there
// into a three-entry result buffer. The first byte of a group shows once
// its fourth character has gone through both, or later while earlier
// words still wait in the buffer. One character is accepted every cycle
// unless the input stalls: characters that emit nothing pass while the
// buffer drains, and one that emits results waits only until the buffer
// holds at most one word being taken. The output port sets the sustained
// rate, one word per cycle unless stalled; a group of four gives at most three.
module base64_stream_decoder
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       is_final,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] status,
    output logic       run_last,
    output logic       stream_end
);

    logic        in_full_reg, in_full_next;
    logic [7:0]  in_char_reg;
    logic        in_final_reg;

    logic [17:0] grp_bits_reg, grp_bits_next;
    logic [1:0]  grp_pos_reg, grp_pos_next;
    logic        third_pad_reg, third_pad_next;

    logic [7:0]  res_byte_reg [3];
    logic [7:0]  res_byte_next [3];
    logic [1:0]  res_cnt_reg, res_cnt_next;
    status_t     res_status_reg, res_status_next;
    logic        res_end_reg, res_end_next;

    sextet_t     sx;
    logic        produces;
    logic        buf_free;
    logic        process;
    logic        take;
    logic        accept;
    logic [23:0] triple;
    logic [1:0]  n_bytes;

    assign sx       = sextet_of(in_char_reg);
    assign take     = out_valid && !out_stall;
    assign buf_free = (res_cnt_reg == 2'd0) || (res_cnt_reg == 2'd1 && !out_stall);
    assign produces = !sx.ok || in_final_reg || (grp_pos_reg == 2'd3);
    assign process  = in_full_reg && (!produces || buf_free);
    assign in_stall = in_full_reg && !process;
    assign accept   = in_valid && !in_stall;
    assign triple   = {grp_bits_reg, sx.value};

    always_comb
    begin
        n_bytes = 2'd3;
        if (in_final_reg && in_char_reg == PAD_CHAR)
        begin
            n_bytes = n_bytes - 2'd1;
        end
        if (in_final_reg && third_pad_reg)
        begin
            n_bytes = n_bytes - 2'd1;
        end
    end

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (process)
        begin
            in_full_next = 1'b0;
        end
    end

    always_comb
    begin
        grp_bits_next   = grp_bits_reg;
        grp_pos_next    = grp_pos_reg;
        third_pad_next  = third_pad_reg;
        res_byte_next   = res_byte_reg;
        res_cnt_next    = res_cnt_reg;
        res_status_next = res_status_reg;
        res_end_next    = res_end_reg;

        if (take)
        begin
            res_byte_next[0] = res_byte_reg[1];
            res_byte_next[1] = res_byte_reg[2];
            res_byte_next[2] = res_byte_reg[2];
            res_cnt_next     = res_cnt_reg - 2'd1;
        end

        if (process)
        begin
            if (!sx.ok)
            begin
                res_byte_next[0] = 8'd0;
                res_cnt_next     = 2'd1;
                res_status_next  = STATUS_INVALID;
                res_end_next     = in_final_reg;
                grp_bits_next    = 18'd0;
                grp_pos_next     = 2'd0;
                third_pad_next   = 1'b0;
            end
            else if (grp_pos_reg == 2'd3)
            begin
                res_byte_next[0] = triple[23:16];
                res_byte_next[1] = triple[15:8];
                res_byte_next[2] = triple[7:0];
                res_cnt_next     = n_bytes;
                res_status_next  = STATUS_DATA;
                res_end_next     = in_final_reg;
                grp_bits_next    = 18'd0;
                grp_pos_next     = 2'd0;
                third_pad_next   = 1'b0;
            end
            else if (in_final_reg)
            begin
                res_byte_next[0] = 8'd0;
                res_cnt_next     = 2'd1;
                res_status_next  = STATUS_LENGTH;
                res_end_next     = 1'b1;
                grp_bits_next    = 18'd0;
                grp_pos_next     = 2'd0;
                third_pad_next   = 1'b0;
            end
            else
            begin
                grp_bits_next = {grp_bits_reg[11:0], sx.value};
                grp_pos_next  = grp_pos_reg + 2'd1;
                if (grp_pos_reg == 2'd2)
                begin
                    third_pad_next = (in_char_reg == PAD_CHAR);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg    <= 1'b0;
            grp_bits_reg   <= 18'd0;
            grp_pos_reg    <= 2'd0;
            third_pad_reg  <= 1'b0;
            res_cnt_reg    <= 2'd0;
            res_status_reg <= STATUS_DATA;
            res_end_reg    <= 1'b0;
        end
        else
        begin
            in_full_reg    <= in_full_next;
            grp_bits_reg   <= grp_bits_next;
            grp_pos_reg    <= grp_pos_next;
            third_pad_reg  <= third_pad_next;
            res_cnt_reg    <= res_cnt_next;
            res_status_reg <= res_status_next;
            res_end_reg    <= res_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_char_reg  <= in_char;
            in_final_reg <= is_final;
        end
        res_byte_reg <= res_byte_next;
    end

    assign out_valid  = (res_cnt_reg != 2'd0);
    assign out_byte   = res_byte_reg[0];
    assign status     = res_status_reg;
    assign run_last   = (res_cnt_reg == 2'd1);
    assign stream_end = (res_cnt_reg == 2'd1) && res_end_reg;

endmodule

// ===== design/b64d_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// b64d_checker
// Port-level checks for the Base64 stream decoder, bound into every instance.
// ============================================================================
module b64d_checker
    import b64d_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_char,
    input logic       is_final,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic [1:0] status,
    input logic       run_last,
    input logic       stream_end
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_char) && $stable(is_final))
        else $error("stalled input word changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(status)
            && $stable(run_last) && $stable(stream_end))
        else $error("stalled output word changed");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_end |-> run_last)
        else $error("stream end on a word that is not the last of its run");

    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_DATA |-> run_last && out_byte == 8'd0)
        else $error("error word is not a single zero word");

    a_length_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_LENGTH |-> stream_end)
        else $error("length error does not end the stream");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char    (in_char),
    .is_final   (is_final),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .status     (status),
    .run_last   (run_last),
    .stream_end (stream_end)
);

// ===== tb/base64_stream_decoder_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// base64_stream_decoder_test
// Self-checking bench for the streaming Base64 decoder.
// ============================================================================
// Characters go in one word at a time, with random gaps on the input and
// random stalls on the output. A scoreboard decodes each accepted character
// and queues the bytes and error words it should cause. Each word taken from
// the output is checked against the oldest queued word. The run starts with
// short directed texts: alphabet extremes, padding inside and at the end of
// a text, invalid characters and truncated texts. It then sends random
// texts, mostly well formed, plus texts of random length and raw byte noise.
// ============================================================================
module base64_stream_decoder_test;
    import b64d_pkg::*;

    typedef struct {
        logic [7:0] data;
        status_t    code;
        logic       last_of_char;
        logic       end_of_stream;
    } decoded_t;

    class b64_scoreboard;
        decoded_t    pending_bytes[$];
        logic [17:0] held_bits;
        logic [1:0]  held_count;
        logic        pad_in_third;
        int unsigned mismatches;
        int unsigned words_checked;
        int unsigned data_words;
        int unsigned error_words;

        function new();
            clear_group();
            mismatches    = 0;
            words_checked = 0;
            data_words    = 0;
            error_words   = 0;
        endfunction

        function void clear_group();
            held_bits    = '0;
            held_count   = '0;
            pad_in_third = 1'b0;
        endfunction

        function bit char_value(input logic [7:0] c, output logic [5:0] v);
            v = 6'd0;
            if (c >= "A" && c <= "Z")
                v = 6'(c - "A");
            else if (c >= "a" && c <= "z")
                v = 6'(c - "a" + 8'd26);
            else if (c >= "0" && c <= "9")
                v = 6'(c - "0" + 8'd52);
            else if (c == PLUS_CHAR)
                v = 6'd62;
            else if (c == SLASH_CHAR)
                v = 6'd63;
            else if (c != PAD_CHAR)
                return 1'b0;
            return 1'b1;
        endfunction

        function void queue_word(logic [7:0] d, status_t s, logic l, logic e);
            decoded_t w;
            w.data          = d;
            w.code          = s;
            w.last_of_char  = l;
            w.end_of_stream = e;
            pending_bytes.push_back(w);
        endfunction

        function void note_char(input logic [7:0] c, input logic fin);
            logic [5:0]  v;
            logic [23:0] triple;
            int          n;
            if (!char_value(c, v))
            begin
                queue_word(8'h00, STATUS_INVALID, 1'b1, fin);
                clear_group();
                return;
            end
            if (held_count != 2'd3)
            begin
                held_bits = {held_bits[11:0], v};
                if (held_count == 2'd2)
                    pad_in_third = (c == PAD_CHAR);
                held_count = held_count + 2'd1;
                if (fin)
                begin
                    queue_word(8'h00, STATUS_LENGTH, 1'b1, 1'b1);
                    clear_group();
                end
                return;
            end
            triple = {held_bits, v};
            n = 3;
            if (fin)
            begin
                if (c == PAD_CHAR)
                    n--;
                if (pad_in_third)
                    n--;
            end
            for (int k = 0; k < n; k++)
                queue_word(triple[23 - 8 * k -: 8], STATUS_DATA, k == n - 1,
                           (k == n - 1) && fin);
            clear_group();
        endfunction

        task report(input string what);
            if (mismatches < 20)
                $display("%0t ns MISMATCH %s", $time, what);
            mismatches++;
        endtask

        task check_word(input logic [7:0] d, input logic [1:0] s,
                        input logic l, input logic e);
            decoded_t want;
            if (pending_bytes.size() == 0)
            begin
                report($sformatf("word with none due: byte %02h status %0d last %0b end %0b",
                                 d, s, l, e));
                return;
            end
            want = pending_bytes.pop_front();
            words_checked++;
            if (want.code == STATUS_DATA)
                data_words++;
            else
                error_words++;
            if (d !== want.data || s !== want.code || l !== want.last_of_char
                || e !== want.end_of_stream)
                report($sformatf({"got byte %02h status %0d last %0b end %0b, ",
                                  "want byte %02h status %0d last %0b end %0b"},
                                 d, s, l, e, want.data, want.code,
                                 want.last_of_char, want.end_of_stream));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_char;
    logic       is_final;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       run_last;
    logic       stream_end;

    b64_scoreboard board = new();
    bit            steady;
    int unsigned   chars_sent;
    int unsigned   streams_sent;

    base64_stream_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_char    (in_char),
        .is_final   (is_final),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .status     (status),
        .run_last   (run_last),
        .stream_end (stream_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("base64_stream_decoder test failed");
        $finish;
    end

    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] symbol_char(input int v);
        if (v < 26)
            return 8'("A" + v);
        if (v < 52)
            return 8'("a" + v - 26);
        if (v < 62)
            return 8'("0" + v - 52);
        if (v == 62)
            return PLUS_CHAR;
        return SLASH_CHAR;
    endfunction

    function automatic logic [7:0] random_symbol(input int pad_pct);
        if ($urandom_range(0, 99) < pad_pct)
            return PAD_CHAR;
        return symbol_char($urandom_range(0, 63));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        gap = (steady || $urandom_range(0, 99) < 55) ? 0 : idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        is_final <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_char(c, fin);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input bit ends);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], ends && (i == s.len() - 1));
        if (ends)
            streams_sent++;
    endtask

    task automatic random_stream();
        logic [7:0] tail[4];
        int         r;
        int         groups;
        int         len;
        r = $urandom_range(0, 99);
        steady = ($urandom_range(0, 4) == 0);
        if (r < 80)
        begin
            groups = $urandom_range(0, 3);
            for (int i = 0; i < 4 * groups; i++)
                send_char(random_symbol(5), 1'b0);
            for (int i = 0; i < 4; i++)
                tail[i] = random_symbol(0);
            case ($urandom_range(0, 3))
                1: tail[3] = PAD_CHAR;
                2:
                begin
                    tail[2] = PAD_CHAR;
                    tail[3] = PAD_CHAR;
                end
                3: tail[2] = PAD_CHAR;
                default: ;
            endcase
            for (int i = 0; i < 4; i++)
                send_char(tail[i], i == 3);
            streams_sent++;
        end
        else if (r < 90)
        begin
            len = $urandom_range(1, 11);
            for (int i = 0; i < len; i++)
                send_char(random_symbol(10), i == len - 1);
            streams_sent++;
        end
        else
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_char(8'($urandom_range(0, 255)),
                          (i == len - 1) && $urandom_range(0, 1));
        end
    endtask

    // Output back-pressure: runs of stall, with calm stretches.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!steady && $urandom_range(0, 99) < 25)
                    hold_left = idle_length();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_word(out_byte, status, run_last, stream_end);
    end

    initial
    begin
        int waited;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_char      = 8'h00;
        is_final     = 1'b0;
        steady       = 1'b0;
        chars_sent   = 0;
        streams_sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_text("AZaz", 1'b0);
        send_text("09+/", 1'b0);
        send_text("AA==", 1'b0);
        send_char("A", 1'b0);
        send_char(8'h00, 1'b0);
        send_text("QQ==", 1'b1);
        send_text("AB=C", 1'b1);
        send_text("Q", 1'b1);
        send_char("A", 1'b0);
        send_char("B", 1'b0);
        send_char(8'hFF, 1'b1);

        while (chars_sent < 400)
            random_stream();
        in_valid <= 1'b0;
        steady = 1'b1;

        waited = 0;
        while (board.pending_bytes.size() > 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (board.pending_bytes.size() > 0)
            board.report($sformatf("%0d words never came out",
                                   board.pending_bytes.size()));

        $display("Sent %0d characters in about %0d texts; checked %0d words",
                 chars_sent, streams_sent, board.words_checked);
        $display("(%0d bytes, %0d error words), %0d mismatches",
                 board.data_words, board.error_words, board.mismatches);
        if (board.mismatches == 0)
            $display("base64_stream_decoder test passed");
        else
            $display("base64_stream_decoder test failed");
        $finish;
    end

endmodule

// ===== base64_stream_decoder.f =====
design/b64d_pkg.sv
design/base64_stream_decoder.sv
design/b64d_checker.sv
tb/base64_stream_decoder_test.sv
